[design/rsia_pkg.sv]
// ----------------------------------------------------------------------------
// rsia_pkg
// Shared constants and helpers for the signed integer to radix text block.
// ----------------------------------------------------------------------------
package rsia_pkg;

   localparam int RADIX_BITS = 6;
   localparam int CHAR_BITS  = 7;

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_BITS-1:0] DIGIT_TEN   = 6'd10;

   localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 7'h30;  // '0'
   localparam logic [CHAR_BITS-1:0] ASCII_SEVEN = 7'h37;  // '7', so 10 maps to 'A'
   localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 7'h2D;  // '-'

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] digit);
      logic [CHAR_BITS-1:0] d;
      d = {1'b0, digit};
      if (digit < DIGIT_TEN) begin
         return d + ASCII_ZERO;
      end
      return d + ASCII_SEVEN;
   endfunction

endpackage

[design/rsia_req_if.sv]
// ----------------------------------------------------------------------------
// rsia_req_if
// Input channel: one signed number per word.
// ----------------------------------------------------------------------------
interface rsia_req_if #(
   parameter int VALUE_BITS = 32
) ();
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

[design/rsia_rsp_if.sv]
// ----------------------------------------------------------------------------
// rsia_rsp_if
// Result channel: one ASCII character per word, last flags the final one.
// ----------------------------------------------------------------------------
interface rsia_rsp_if ();
   logic                          valid;
   logic                          ready;
   logic [rsia_pkg::CHAR_BITS-1:0] character;
   logic                          last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

[design/rsia_csr_if.sv]
// ----------------------------------------------------------------------------
// rsia_csr_if
// Configuration write channel carrying the radix register.
// ----------------------------------------------------------------------------
interface rsia_csr_if ();
   logic                           valid;
   logic                           ready;
   logic [rsia_pkg::RADIX_BITS-1:0] radix;

   modport source (output valid, output radix, input ready);
   modport sink   (input valid, input radix, output ready);
endinterface

[design/rsia_ram.sv]
// ----------------------------------------------------------------------------
// rsia_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsia_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/rsia_divider.sv]
// ----------------------------------------------------------------------------
// rsia_divider
// Restoring divider, one quotient bit per cycle: dividend by a 6-bit radix.
// ----------------------------------------------------------------------------
module rsia_divider #(
   parameter int VALUE_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [VALUE_BITS-1:0]           dividend,
   input  logic [rsia_pkg::RADIX_BITS-1:0] divisor,
   output logic                            done,
   output logic [VALUE_BITS-1:0]           quotient,
   output logic [rsia_pkg::RADIX_BITS-1:0] remainder
);

   localparam int CW = $clog2(VALUE_BITS);
   localparam int RB = rsia_pkg::RADIX_BITS;
   localparam logic [CW-1:0] LAST_STEP = CW'(VALUE_BITS - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [RB-1:0]         rem_ff, rem_in;
   logic [RB-1:0]         div_ff, div_in;

   logic [RB:0] trial;
   logic [RB:0] diff;
   logic        fits;

   assign trial = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign fits  = trial >= {1'b0, div_ff};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_BITS-2:0], fits};
         rem_in = fits ? diff[RB-1:0] : trial[RB-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[design/signed_int_to_radix_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int_to_radix_ascii
// Prints a signed number as ASCII text in the configured radix.
// ----------------------------------------------------------------------------
// One number is taken at a time. Its magnitude is divided by the radix in a
// shared restoring divider, one quotient bit per cycle; digits land least
// significant first in a small digit buffer. The text then leaves most
// significant first: a '-' for a negative number, then each digit, with each
// character read in ST_FETCH and loaded in ST_LOAD through the buffer's
// registered read port. A new number is taken while the final character
// still waits in the output register. Radix values 0 and 1 act as radix 2.
// ----------------------------------------------------------------------------
module signed_int_to_radix_ascii #(
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   rsia_req_if.sink    req_bus,
   rsia_rsp_if.source  rsp_bus,
   rsia_csr_if.sink    csr_bus
);

   localparam int AW = $clog2(VALUE_BITS);
   localparam int NW = $clog2(VALUE_BITS + 1);
   localparam int RB = rsia_pkg::RADIX_BITS;
   localparam int CB = rsia_pkg::CHAR_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SIGN,
      ST_FETCH,
      ST_LOAD
   } state_type;

   state_type state_ff;
   logic [RB-1:0] radix_ff;
   logic          neg_ff;
   logic [NW-1:0] ndig_ff;
   logic [AW-1:0] idx_ff;
   logic          rsp_valid_ff;
   logic [CB-1:0] rsp_char_ff;
   logic          rsp_last_ff;

   logic                  req_take;
   logic                  rsp_free;
   logic                  rsp_load;
   logic [VALUE_BITS-1:0] raw;
   logic [VALUE_BITS-1:0] mag;
   logic [RB-1:0]         base;

   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quo;
   logic [RB-1:0]         div_rem;

   logic          ram_we;
   logic          ram_re;
   logic [CB-1:0] ram_rd_data;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_load      = rsp_free && ((state_ff == ST_SIGN) || (state_ff == ST_LOAD));

   assign raw  = req_bus.value;
   assign mag  = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
   assign base = (radix_ff < rsia_pkg::RADIX_MIN) ? rsia_pkg::RADIX_MIN : radix_ff;

   assign ram_we = (state_ff == ST_DIV) && div_done;
   assign ram_re = (state_ff == ST_FETCH);

   always_comb begin
      div_start    = 1'b0;
      div_dividend = mag;
      if (req_take) begin
         div_start = 1'b1;
      end else if (ram_we && (div_quo != '0)) begin
         div_start    = 1'b1;
         div_dividend = div_quo;
      end
   end

   rsia_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (base),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   rsia_ram #(
      .WIDTH (CB),
      .DEPTH (VALUE_BITS)
   ) u_digits (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ndig_ff[AW-1:0]),
      .wr_data (rsia_pkg::digit_char(div_rem)),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= rsia_pkg::RADIX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            radix_ff <= csr_bus.radix;
         end
         if (rsp_valid_ff && rsp_bus.ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  neg_ff   <= raw[VALUE_BITS-1];
                  ndig_ff  <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  ndig_ff <= ndig_ff + 1'b1;
                  if (div_quo == '0) begin
                     idx_ff   <= ndig_ff[AW-1:0];
                     state_ff <= neg_ff ? ST_SIGN : ST_FETCH;
                  end
               end
            end
            ST_SIGN: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_char_ff  <= rsia_pkg::ASCII_MINUS;
                  rsp_last_ff  <= 1'b0;
                  state_ff     <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_char_ff  <= ram_rd_data;
                  rsp_last_ff  <= (idx_ff == '0);
                  if (idx_ff == '0) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff   <= idx_ff - 1'b1;
                     state_ff <= ST_FETCH;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.character = rsp_char_ff;
   assign rsp_bus.last      = rsp_last_ff;

endmodule
